/* src/lidar_sector_min_range_core_assert.svh */
// Assertion macros shared by the lidar sector minimum range design.
`ifndef LIDAR_SECTOR_MIN_RANGE_CORE_ASSERT_SVH
`define LIDAR_SECTOR_MIN_RANGE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define LSMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define LSMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lsmr_pkg.sv */
// Package with types and constants of the lidar sector minimum range core.
`timescale 1ns / 1ps

package lsmr_pkg;

    localparam int RANGE_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIN_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd4;

    // Reset values: 350 deg, 10 deg, 500 mm, 0 deg, one step of 182 units.
    localparam logic [CFG_DATA_W-1:0] RST_WIN_START  = 16'd63716;
    localparam logic [CFG_DATA_W-1:0] RST_WIN_END    = 16'd1820;
    localparam logic [CFG_DATA_W-1:0] RST_RANGE_LIM  = 16'd500;
    localparam logic [CFG_DATA_W-1:0] RST_SCAN_START = 16'd0;
    localparam logic [CFG_DATA_W-1:0] RST_ANGLE_STEP = 16'd182;

    // One lidar sample word.
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               range_valid;
        logic               last_sample;
    } t_sample;

    // One per-scan result word.
    typedef struct packed {
        logic               obstacle_found;
        logic [RANGE_W-1:0] nearest_range_mm;
    } t_result;

endpackage

/* src/lsmr_sample_if.sv */
// Valid/ready channel carrying lidar sample words.
`timescale 1ns / 1ps

interface lsmr_sample_if;
    logic              valid;
    logic              ready;
    lsmr_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/lsmr_result_if.sv */
// Valid/ready channel carrying per-scan result words.
`timescale 1ns / 1ps

interface lsmr_result_if;
    logic              valid;
    logic              ready;
    lsmr_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/lidar_sector_min_range_core.sv */
// Lidar sector minimum range core: nearest in-window obstacle once per scan.
// A sample word is registered, then processed; a last-sample result is loaded into the result register
// when its sample leaves the input register, which a last sample does only once the result register is
// free. Throughput: one sample word per cycle while no last sample waits on a full result register, set
// by the single input register and the angle/minimum update. Reset (synchronous, active low) restores
// register defaults, clears scan state and empties both the input and result registers.
`timescale 1ns / 1ps

module lidar_sector_min_range_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsmr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsmr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lsmr_sample_if.sink                         i_smp,
    lsmr_result_if.source                       o_res
);

`include "lidar_sector_min_range_core_assert.svh"

    localparam int RW = lsmr_pkg::RANGE_W;
    localparam int CW = lsmr_pkg::CFG_DATA_W;

    // Configuration registers.
    logic [CW-1:0] r_win_start;
    logic [CW-1:0] r_win_end;
    logic [CW-1:0] r_range_lim;
    logic [CW-1:0] r_scan_start;
    logic [CW-1:0] r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start  <= lsmr_pkg::RST_WIN_START;
            r_win_end    <= lsmr_pkg::RST_WIN_END;
            r_range_lim  <= lsmr_pkg::RST_RANGE_LIM;
            r_scan_start <= lsmr_pkg::RST_SCAN_START;
            r_angle_step <= lsmr_pkg::RST_ANGLE_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsmr_pkg::REG_WIN_START:  r_win_start  <= i_cfg_data;
                lsmr_pkg::REG_WIN_END:    r_win_end    <= i_cfg_data;
                lsmr_pkg::REG_RANGE_LIM:  r_range_lim  <= i_cfg_data;
                lsmr_pkg::REG_SCAN_START: r_scan_start <= i_cfg_data;
                lsmr_pkg::REG_ANGLE_STEP: r_angle_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Register angles resized to the angle width: zero-extended or truncated,
    // and the step sign-extended or truncated.
    logic [ANGLE_BITS+CW-1:0] ws_ext, we_ext, ss_ext, st_ext;
    logic [ANGLE_BITS-1:0]    win_s, win_e, scan_s, step_a;

    assign ws_ext = {{ANGLE_BITS{1'b0}}, r_win_start};
    assign we_ext = {{ANGLE_BITS{1'b0}}, r_win_end};
    assign ss_ext = {{ANGLE_BITS{1'b0}}, r_scan_start};
    assign st_ext = {{ANGLE_BITS{r_angle_step[CW-1]}}, r_angle_step};
    assign win_s  = ws_ext[ANGLE_BITS-1:0];
    assign win_e  = we_ext[ANGLE_BITS-1:0];
    assign scan_s = ss_ext[ANGLE_BITS-1:0];
    assign step_a = st_ext[ANGLE_BITS-1:0];

    // Input register stage.
    logic              r_s1_valid;
    lsmr_pkg::t_sample r_s1;
    logic              s1_fire;
    logic              s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_smp.valid) begin
            r_s1 <= i_smp.data;
        end
    end

    // Result register and its handshake with the downstream side.
    logic              r_out_valid;
    lsmr_pkg::t_result r_out;

    // A sample without a result never waits on the output; a last sample
    // waits only for a free result register.
    assign s1_fire  = r_s1_valid && (!r_s1.last_sample || !r_out_valid || o_res.ready);
    assign s1_ready = !r_s1_valid || s1_fire;

    assign i_smp.ready = s1_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Scan state.
    logic                  r_in_scan;
    logic [ANGLE_BITS-1:0] r_angle;
    logic                  r_found;
    logic [RW-1:0]         r_min;

    // Window test, qualification and running minimum for the sample in stage one.
    logic [ANGLE_BITS-1:0] cur_angle;
    logic                  in_win;
    logic                  qual;
    logic                  n_found;
    logic [RW-1:0]         n_min;

    always_comb begin
        cur_angle = r_in_scan ? r_angle : scan_s;
        if (win_s <= win_e) begin
            in_win = (cur_angle >= win_s) && (cur_angle <= win_e);
        end else begin
            in_win = (cur_angle >= win_s) || (cur_angle <= win_e);
        end
        qual = r_s1.range_valid && (r_s1.range_mm != '0) && in_win
               && (r_s1.range_mm <= r_range_lim);
        n_found = r_found || qual;
        if (qual && (!r_found || (r_s1.range_mm < r_min))) begin
            n_min = r_s1.range_mm;
        end else begin
            n_min = r_min;
        end
    end

    // State update; the last sample of a scan clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_scan <= 1'b0;
            r_found   <= 1'b0;
            r_min     <= '0;
            r_angle   <= scan_s;
        end else if (s1_fire) begin
            if (r_s1.last_sample) begin
                r_in_scan <= 1'b0;
                r_found   <= 1'b0;
                r_min     <= '0;
                r_angle   <= scan_s;
            end else begin
                r_in_scan <= 1'b1;
                r_found   <= n_found;
                r_min     <= n_min;
                r_angle   <= cur_angle + step_a;
            end
        end
    end

    // Result register: loaded by a last sample, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.last_sample) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.last_sample) begin
            r_out.obstacle_found   <= n_found;
            r_out.nearest_range_mm <= n_found ? n_min : '0;
        end
    end

    // Checks on scan bookkeeping and result contents.
    `LSMR_ASSERT_NOW(a_empty_result_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.obstacle_found, r_out.nearest_range_mm == '0,
        "result without obstacle carries a nonzero range")
    `LSMR_ASSERT_NOW(a_found_min_nonzero, i_clk, i_rst_n,
        r_found, r_min != '0,
        "running minimum is zero although an obstacle was found")
    `LSMR_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n,
        s1_fire && r_s1.last_sample, !r_found && !r_in_scan && (r_min == '0),
        "scan state not cleared after the last sample")
    `LSMR_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        s1_fire && r_s1.last_sample, r_out_valid,
        "last sample did not load a result word")

endmodule

/* tb/sv/lsmr_sector_min_monitor.sv */
// Scan result monitor for the lidar sector minimum range core: predicts and compares.
`timescale 1ns / 1ps

module lsmr_sector_min_monitor #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsmr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsmr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lsmr_sample_if                          smp,
    lsmr_result_if                          res,
    output int                              o_waiting,
    output int                              o_mismatches,
    output int                              o_scans_checked
);

    // Local copy of the configuration registers.
    logic [lsmr_pkg::CFG_DATA_W-1:0] win_start;
    logic [lsmr_pkg::CFG_DATA_W-1:0] win_end;
    logic [lsmr_pkg::CFG_DATA_W-1:0] range_limit;
    logic [lsmr_pkg::CFG_DATA_W-1:0] scan_start;
    logic [lsmr_pkg::CFG_DATA_W-1:0] angle_step;

    // Local copy of the scan state.
    logic [ANGLE_BITS-1:0]        sweep_angle;
    logic [lsmr_pkg::RANGE_W-1:0] nearest_so_far;
    logic                         hit_seen;
    logic                         scan_open;

    // Results owed by the core, oldest first.
    lsmr_pkg::t_result scan_results_due[$];
    int                mismatch_count;
    int                scans_checked;

    task automatic report_mismatch(input string what);
        $display("%0t ns: scan result mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic angle_in_window(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS-1:0] s;
        logic [ANGLE_BITS-1:0] e;
        s = ANGLE_BITS'(win_start);
        e = ANGLE_BITS'(win_end);
        // A start above the end means the window wraps through zero.
        if (s <= e) return (a >= s) && (a <= e);
        return (a >= s) || (a <= e);
    endfunction

    // Fold one sample word into the scan; the last one closes the scan with a result.
    function automatic void fold_sample(input lsmr_pkg::t_sample w);
        lsmr_pkg::t_result r;
        if (!scan_open) begin
            sweep_angle = ANGLE_BITS'(scan_start);
            scan_open   = 1'b1;
        end
        if (w.range_valid && w.range_mm != '0 && angle_in_window(sweep_angle) &&
            w.range_mm <= range_limit) begin
            if (!hit_seen || w.range_mm < nearest_so_far) nearest_so_far = w.range_mm;
            hit_seen = 1'b1;
        end
        sweep_angle = sweep_angle + ANGLE_BITS'(signed'(angle_step));
        if (w.last_sample) begin
            r.obstacle_found   = hit_seen;
            r.nearest_range_mm = hit_seen ? nearest_so_far : '0;
            scan_results_due.push_back(r);
            nearest_so_far = '0;
            hit_seen       = 1'b0;
            scan_open      = 1'b0;
            sweep_angle    = ANGLE_BITS'(scan_start);
        end
    endfunction

    // Track register writes, predict on each sample word, compare each result word.
    always @(posedge i_clk) begin
        lsmr_pkg::t_result want;
        lsmr_pkg::t_result got;
        if (!i_rst_n) begin
            win_start      = lsmr_pkg::RST_WIN_START;
            win_end        = lsmr_pkg::RST_WIN_END;
            range_limit    = lsmr_pkg::RST_RANGE_LIM;
            scan_start     = lsmr_pkg::RST_SCAN_START;
            angle_step     = lsmr_pkg::RST_ANGLE_STEP;
            sweep_angle    = ANGLE_BITS'(lsmr_pkg::RST_SCAN_START);
            nearest_so_far = '0;
            hit_seen       = 1'b0;
            scan_open      = 1'b0;
            scan_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsmr_pkg::REG_WIN_START:  win_start   = i_cfg_data;
                    lsmr_pkg::REG_WIN_END:    win_end     = i_cfg_data;
                    lsmr_pkg::REG_RANGE_LIM:  range_limit = i_cfg_data;
                    lsmr_pkg::REG_SCAN_START: scan_start  = i_cfg_data;
                    lsmr_pkg::REG_ANGLE_STEP: angle_step  = i_cfg_data;
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready) fold_sample(smp.data);
            if (res.valid && res.ready) begin
                got = res.data;
                if (scan_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word found=%0b nearest=%0d",
                                              got.obstacle_found, got.nearest_range_mm));
                end else begin
                    want = scan_results_due.pop_front();
                    scans_checked++;
                    if (got.obstacle_found !== want.obstacle_found)
                        report_mismatch($sformatf("obstacle_found got %0b want %0b",
                                                  got.obstacle_found, want.obstacle_found));
                    if (got.nearest_range_mm !== want.nearest_range_mm)
                        report_mismatch($sformatf("nearest_range_mm got %0d want %0d",
                                                  got.nearest_range_mm, want.nearest_range_mm));
                end
            end
        end
        o_waiting       <= scan_results_due.size();
        o_mismatches    <= mismatch_count;
        o_scans_checked <= scans_checked;
    end

    initial begin
        mismatch_count  = 0;
        scans_checked   = 0;
        o_waiting       = 0;
        o_mismatches    = 0;
        o_scans_checked = 0;
    end

endmodule

/* tb/sv/tb.sv */
// Top of the lidar sector minimum range testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int ANGLE_BITS  = 16;
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_GAP  = 4;
    localparam int SCAN_ITEMS  = 56;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [lsmr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lsmr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lsmr_sample_if smp_ch ();
    lsmr_result_if res_ch ();

    int scans_waiting;
    int mismatches;
    int scans_checked;

    int                           src_idle_pct  = 0;
    int                           sink_idle_pct = 0;
    int                           hold_requests = 0;
    int                           holds_served;
    int                           hold_left;
    int                           quiet_cycles;
    int                           words_sent    = 0;
    int                           settings_used = 0;
    logic [lsmr_pkg::RANGE_W-1:0] cur_limit     = lsmr_pkg::RST_RANGE_LIM;

    lidar_sector_min_range_core #(
        .ANGLE_BITS(ANGLE_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_smp     (smp_ch),
        .o_res     (res_ch)
    );

    lsmr_sector_min_monitor #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .smp            (smp_ch),
        .res            (res_ch),
        .o_waiting      (scans_waiting),
        .o_mismatches   (mismatches),
        .o_scans_checked(scans_checked)
    );

    always #5 i_clk = ~i_clk;

    // Result receiver: random stalls, plus a long hold-off whenever one is requested.
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            holds_served <= 0;
            hold_left    <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: too long without any word moving on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample word, with a random gap first, and return at its acceptance edge.
    task automatic put_sample(input logic [lsmr_pkg::RANGE_W-1:0] range, input logic valid,
                              input logic last);
        lsmr_pkg::t_sample w;
        w.range_mm    = range;
        w.range_valid = valid;
        w.last_sample = last;
        while ($urandom_range(99) < src_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.data  <= w;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop sending and wait until every owed result word has come back.
    task automatic settle();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (scans_waiting != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // Register write; the enable stays high so that writes can follow back to back.
    task automatic write_reg(input logic [lsmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lsmr_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Load all five registers, plus a write to an index past the list that must be ignored.
    task automatic load_settings(input logic [lsmr_pkg::CFG_DATA_W-1:0] ws,
                                 input logic [lsmr_pkg::CFG_DATA_W-1:0] we,
                                 input logic [lsmr_pkg::CFG_DATA_W-1:0] lim,
                                 input logic [lsmr_pkg::CFG_DATA_W-1:0] ss,
                                 input logic [lsmr_pkg::CFG_DATA_W-1:0] step);
        logic [lsmr_pkg::CFG_IDX_W-1:0] junk_idx;
        junk_idx = lsmr_pkg::CFG_IDX_W'(lsmr_pkg::REG_ANGLE_STEP + 1 + $urandom_range(2));
        write_reg(lsmr_pkg::REG_WIN_START, ws);
        write_reg(lsmr_pkg::REG_WIN_END, we);
        write_reg(lsmr_pkg::REG_RANGE_LIM, lim);
        write_reg(lsmr_pkg::REG_SCAN_START, ss);
        write_reg(lsmr_pkg::REG_ANGLE_STEP, step);
        write_reg(junk_idx, 16'($urandom));
        i_cfg_we  <= 1'b0;
        cur_limit = lim;
        settings_used++;
    endtask

    function automatic logic [lsmr_pkg::CFG_DATA_W-1:0] pick_value(
        input logic [lsmr_pkg::CFG_DATA_W-1:0] lo,
        input logic [lsmr_pkg::CFG_DATA_W-1:0] hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            default: return lsmr_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic load_random_settings();
        logic [lsmr_pkg::CFG_DATA_W-1:0] step;
        step = pick_value(16'h8000, 16'h7FFF);
        // Small steps keep a scan sweeping through the window instead of hopping over it.
        if ($urandom_range(2) == 0) step = lsmr_pkg::CFG_DATA_W'($urandom_range(800) - 400);
        load_settings(pick_value('0, '1), pick_value('0, '1), pick_value('0, '1),
                      pick_value('0, '1), step);
    endtask

    // Ranges cluster below and at the limit so that minimums keep changing.
    function automatic logic [lsmr_pkg::RANGE_W-1:0] random_range();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return cur_limit;
            3, 4, 5, 6: return lsmr_pkg::RANGE_W'($urandom_range(cur_limit));
            default: return lsmr_pkg::RANGE_W'($urandom);
        endcase
    endfunction

    task automatic send_random_scan(input int max_len);
        int len;
        len = $urandom_range(max_len, 1);
        for (int n = 1; n <= len; n++)
            put_sample(random_range(), $urandom_range(99) < 85, n == len);
    endtask

    // Stimulus: directed scans, then random scans under three idling regimes.
    initial begin
        int first_word;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        smp_ch.valid = 1'b0;
        smp_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 35;
        sink_idle_pct <= 57;

        // Reset settings: skipped zero, limit equality, over-limit, invalid, tie.
        put_sample(16'd0, 1'b1, 1'b0);
        put_sample(16'd500, 1'b1, 1'b0);
        put_sample(16'd501, 1'b1, 1'b0);
        put_sample(16'd100, 1'b0, 1'b0);
        put_sample(16'd300, 1'b1, 1'b0);
        put_sample(16'd300, 1'b1, 1'b0);
        put_sample(16'hFFFF, 1'b1, 1'b1);
        // One-sample scans: nothing found, and the smallest range found.
        put_sample(16'd0, 1'b1, 1'b1);
        put_sample(16'd1, 1'b1, 1'b1);
        settle();

        // Window wrapping through zero with only two angles, scan starting at the top.
        load_settings('1, '0, '1, '1, 16'd1);
        put_sample(16'hFFFF, 1'b1, 1'b0);
        put_sample(16'd2, 1'b1, 1'b0);
        put_sample(16'd1, 1'b1, 1'b1);
        settle();

        // Full window with a zero limit and the most negative step.
        load_settings('0, '1, '0, '0, 16'h8000);
        put_sample(16'd1, 1'b1, 1'b0);
        put_sample(16'hFFFF, 1'b1, 1'b1);
        settle();

        // Single-angle window with the largest positive step.
        load_settings('0, '0, '1, '0, 16'h7FFF);
        put_sample(16'd7, 1'b1, 1'b0);
        put_sample(16'd3, 1'b1, 1'b0);
        put_sample(16'd5, 1'b1, 1'b1);
        settle();

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin src_idle_pct = 35; sink_idle_pct <= 57; end
                1: begin src_idle_pct = 57; sink_idle_pct <= 35; end
                default: begin src_idle_pct = 0; sink_idle_pct <= 0; end
            endcase
            for (int k = 0; k < 4; k++) begin
                settle();
                load_random_settings();
                first_word = words_sent;
                // Back-pressure: result side holds off while short scans keep coming.
                if (regime == 2 && k == 0) begin
                    hold_requests <= hold_requests + 1;
                    repeat (12) send_random_scan(2);
                end
                // Sender drains mid-setting before carrying on.
                if (regime == 1 && k == 2) begin
                    repeat (3) send_random_scan(12);
                    settle();
                end
                while (words_sent - first_word < SCAN_ITEMS)
                    send_random_scan(($urandom_range(9) == 0) ? 40 : 12);
            end
        end
        settle();
        repeat (2 * SETTLE_GAP) @(posedge i_clk);

        $display("Run covered %0d sample words over %0d register settings.",
                 words_sent, settings_used);
        $display("%0d scan results compared, with wrapped, full and single-angle windows.",
                 scans_checked);
        if (mismatches == 0 && scans_waiting == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/lsmr_pkg.sv
src/lsmr_sample_if.sv
src/lsmr_result_if.sv
src/lidar_sector_min_range_core.sv
tb/sv/lsmr_sector_min_monitor.sv
tb/sv/tb.sv
